@@ hw/rtl/sstq_pkg.sv @@
`default_nettype none
package sstq_pkg;

  localparam int NumTimersDef = 16;
  localparam int TimeBitsDef  = 32;

  typedef enum logic [1:0] {
    ReqStart = 2'd0,
    ReqStop  = 2'd1,
    ReqTick  = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  localparam logic KindAck  = 1'b0;
  localparam logic KindFire = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRmRd,
    StRmEv,
    StInsRd,
    StInsEv,
    StPerRd,
    StPerEv,
    StHeadRd,
    StHeadEv,
    StFire,
    StFlush,
    StAck
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  timer_id;
    logic [31:0] interval;
    logic        one_shot;
  } in_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] result_timer;
    logic       now_running;
    logic       last;
  } out_t;

endpackage
`default_nettype wire

@@ hw/rtl/sstq_ram.sv @@
`default_nettype none
module sstq_ram #(
  parameter int Depth = 16,
  parameter int Width = 32,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sstq_ctrl.sv @@
`default_nettype none
module sstq_ctrl #(
  parameter int NUM_TIMERS = sstq_pkg::NumTimersDef,
  parameter int TIME_BITS  = sstq_pkg::TimeBitsDef,
  parameter int Iw = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  parameter int Cw = $clog2(NUM_TIMERS + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sstq_pkg::in_t        in_data_i,
  input  wire logic                 out_free_i,
  output logic                      res_ld_o,
  output sstq_pkg::out_t            res_o,
  output logic                      q_we_o,
  output logic [Iw-1:0]             q_waddr_o,
  output logic [TIME_BITS+Iw-1:0]   q_wdata_o,
  output logic                      q_re_o,
  output logic [Iw-1:0]             q_raddr_o,
  input  wire logic [TIME_BITS+Iw-1:0] q_rdata_i,
  output logic                      p_we_o,
  output logic [Iw-1:0]             p_waddr_o,
  output logic [TIME_BITS:0]        p_wdata_o,
  output logic                      p_re_o,
  output logic [Iw-1:0]             p_raddr_o,
  input  wire logic [TIME_BITS:0]   p_rdata_i
);

  localparam int Tw = TIME_BITS;

  sstq_pkg::state_e state_q, state_d;
  sstq_pkg::req_e   op_q, op_d;
  logic [Iw-1:0]   tgt_q, tgt_d;
  logic [3:0]      rid_q, rid_d;
  logic [Tw-1:0]   when_q, when_d;
  logic [Tw-1:0]   now_q, now_d;
  logic [Cw-1:0]   cnt_q, cnt_d;
  logic [Cw-1:0]   idx_q, idx_d;
  logic [Cw-1:0]   n_q, n_d;
  logic            found_q, found_d;
  logic            pend_q, pend_d;
  logic [Iw-1:0]   pid_q, pid_d;
  logic            prun_q, prun_d;
  logic [NUM_TIMERS-1:0] run_q, run_d;

  logic [Tw-1:0] qr_dl;
  logic [Iw-1:0] qr_id;
  logic [Iw-1:0] in_id;
  logic          in_ok;
  logic [Tw-1:0] in_ival;

  assign qr_dl   = q_rdata_i[Tw+Iw-1:Iw];
  assign qr_id   = q_rdata_i[Iw-1:0];
  assign in_id   = Iw'(in_data_i.timer_id);
  assign in_ok   = 32'(in_data_i.timer_id) < NUM_TIMERS;
  assign in_ival = Tw'(in_data_i.interval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstq_pkg::StIdle;
      op_q    <= sstq_pkg::ReqNone;
      now_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q  <= tgt_d;
    rid_q  <= rid_d;
    when_q <= when_d;
    pid_q  <= pid_d;
    prun_q <= prun_d;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    tgt_d   = tgt_q;
    rid_d   = rid_q;
    when_d  = when_q;
    now_d   = now_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    n_d     = n_q;
    found_d = found_q;
    pend_d  = pend_q;
    pid_d   = pid_q;
    prun_d  = prun_q;
    run_d   = run_q;

    in_stall_o = (state_q != sstq_pkg::StIdle);
    res_ld_o   = 1'b0;
    res_o      = '0;
    q_we_o     = 1'b0;
    q_waddr_o  = idx_q[Iw-1:0];
    q_wdata_o  = {when_q, tgt_q};
    q_re_o     = 1'b0;
    q_raddr_o  = idx_q[Iw-1:0];
    p_we_o     = 1'b0;
    p_waddr_o  = in_id;
    p_wdata_o  = {in_data_i.one_shot, in_ival};
    p_re_o     = 1'b0;
    p_raddr_o  = tgt_q;

    case (state_q)
      sstq_pkg::StIdle: begin
        if (in_valid_i) begin
          case (sstq_pkg::req_e'(in_data_i.req_type))
            sstq_pkg::ReqStart, sstq_pkg::ReqStop: begin
              op_d  = sstq_pkg::req_e'(in_data_i.req_type);
              rid_d = in_data_i.timer_id;
              tgt_d = in_id;
              when_d = now_q + in_ival;
              state_d = sstq_pkg::StAck;
              if (in_ok) begin
                if (op_d == sstq_pkg::ReqStart) begin
                  p_we_o = 1'b1;
                end
                if (run_q[in_id]) begin
                  idx_d   = '0;
                  found_d = 1'b0;
                  state_d = sstq_pkg::StRmRd;
                end else if (op_d == sstq_pkg::ReqStart) begin
                  idx_d   = cnt_q;
                  state_d = sstq_pkg::StInsRd;
                end
              end
            end
            sstq_pkg::ReqTick: begin
              op_d    = sstq_pkg::ReqTick;
              now_d   = now_q + Tw'(1);
              n_d     = '0;
              pend_d  = 1'b0;
              state_d = sstq_pkg::StHeadRd;
            end
            default: begin
            end
          endcase
        end
      end
      sstq_pkg::StRmRd: begin
        if (idx_q == cnt_q) begin
          cnt_d        = cnt_q - Cw'(1);
          run_d[tgt_q] = 1'b0;
          case (op_q)
            sstq_pkg::ReqStart: begin
              idx_d   = cnt_q - Cw'(1);
              state_d = sstq_pkg::StInsRd;
            end
            sstq_pkg::ReqTick: state_d = sstq_pkg::StPerRd;
            default:           state_d = sstq_pkg::StAck;
          endcase
        end else begin
          q_re_o  = 1'b1;
          state_d = sstq_pkg::StRmEv;
        end
      end
      sstq_pkg::StRmEv: begin
        if (found_q) begin
          q_we_o    = 1'b1;
          q_waddr_o = Iw'(idx_q - Cw'(1));
          q_wdata_o = q_rdata_i;
        end
        if (qr_id == tgt_q) begin
          found_d = 1'b1;
        end
        idx_d   = idx_q + Cw'(1);
        state_d = sstq_pkg::StRmRd;
      end
      sstq_pkg::StInsRd: begin
        if (idx_q == '0) begin
          q_we_o       = 1'b1;
          q_waddr_o    = '0;
          cnt_d        = cnt_q + Cw'(1);
          run_d[tgt_q] = 1'b1;
          if (op_q == sstq_pkg::ReqTick) begin
            pend_d  = 1'b1;
            pid_d   = tgt_q;
            prun_d  = 1'b1;
            n_d     = n_q + Cw'(1);
            state_d = sstq_pkg::StHeadRd;
          end else begin
            state_d = sstq_pkg::StAck;
          end
        end else begin
          q_re_o    = 1'b1;
          q_raddr_o = Iw'(idx_q - Cw'(1));
          state_d   = sstq_pkg::StInsEv;
        end
      end
      sstq_pkg::StInsEv: begin
        q_we_o = 1'b1;
        if (qr_dl <= when_q) begin
          cnt_d        = cnt_q + Cw'(1);
          run_d[tgt_q] = 1'b1;
          if (op_q == sstq_pkg::ReqTick) begin
            pend_d  = 1'b1;
            pid_d   = tgt_q;
            prun_d  = 1'b1;
            n_d     = n_q + Cw'(1);
            state_d = sstq_pkg::StHeadRd;
          end else begin
            state_d = sstq_pkg::StAck;
          end
        end else begin
          q_wdata_o = q_rdata_i;
          idx_d     = idx_q - Cw'(1);
          state_d   = sstq_pkg::StInsRd;
        end
      end
      sstq_pkg::StPerRd: begin
        p_re_o  = 1'b1;
        state_d = sstq_pkg::StPerEv;
      end
      sstq_pkg::StPerEv: begin
        if (p_rdata_i[Tw]) begin
          pend_d  = 1'b1;
          pid_d   = tgt_q;
          prun_d  = 1'b0;
          n_d     = n_q + Cw'(1);
          state_d = sstq_pkg::StHeadRd;
        end else begin
          when_d  = now_q + p_rdata_i[Tw-1:0];
          idx_d   = cnt_q;
          state_d = sstq_pkg::StInsRd;
        end
      end
      sstq_pkg::StHeadRd: begin
        if ((cnt_q == '0) || (n_q == Cw'(NUM_TIMERS))) begin
          state_d = pend_q ? sstq_pkg::StFlush : sstq_pkg::StIdle;
        end else begin
          q_re_o    = 1'b1;
          q_raddr_o = '0;
          state_d   = sstq_pkg::StHeadEv;
        end
      end
      sstq_pkg::StHeadEv: begin
        if (qr_dl <= now_q) begin
          tgt_d   = qr_id;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = pend_q ? sstq_pkg::StFire : sstq_pkg::StRmRd;
        end else begin
          state_d = pend_q ? sstq_pkg::StFlush : sstq_pkg::StIdle;
        end
      end
      sstq_pkg::StFire: begin
        if (out_free_i) begin
          res_ld_o = 1'b1;
          res_o    = '{sstq_pkg::KindFire, 4'(pid_q), prun_q, 1'b0};
          pend_d   = 1'b0;
          state_d  = sstq_pkg::StRmRd;
        end
      end
      sstq_pkg::StFlush: begin
        if (out_free_i) begin
          res_ld_o = 1'b1;
          res_o    = '{sstq_pkg::KindFire, 4'(pid_q), prun_q, 1'b1};
          pend_d   = 1'b0;
          state_d  = sstq_pkg::StIdle;
        end
      end
      sstq_pkg::StAck: begin
        if (out_free_i) begin
          res_ld_o = 1'b1;
          res_o    = '{sstq_pkg::KindAck, rid_q,
                       (op_q == sstq_pkg::ReqStart) && (32'(rid_q) < NUM_TIMERS), 1'b1};
          state_d  = sstq_pkg::StIdle;
        end
      end
      default: state_d = sstq_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_software_timer_queue_core.sv @@
`default_nettype none
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | sstq_pkg::in_t
// out     | output    | out_valid_o / out_stall_i | sstq_pkg::out_t
// start or stop: a removal scan of the queue memory if the timer runs, then an insertion scan for start
// tick: per firing one removal scan and, for a periodic timer, one insertion scan of the
// queue memory, and up to N firings per tick
// one input item is worked on at a time; the result register lets the next item in
// reset empties the queue and stops all timers at once, no clearing pass
module sorted_software_timer_queue_core #(
  parameter int NUM_TIMERS = sstq_pkg::NumTimersDef,
  parameter int TIME_BITS  = sstq_pkg::TimeBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire sstq_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sstq_pkg::out_t      out_data_o
);

  localparam int Iw = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic                    out_valid_q, out_valid_d;
  sstq_pkg::out_t          out_q;
  logic                    out_free;
  logic                    res_ld;
  sstq_pkg::out_t          res;
  logic                    q_we, q_re, p_we, p_re;
  logic [Iw-1:0]           q_waddr, q_raddr, p_waddr, p_raddr;
  logic [TIME_BITS+Iw-1:0] q_wdata, q_rdata;
  logic [TIME_BITS:0]      p_wdata, p_rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sstq_ctrl #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .out_free_i(out_free),
    .res_ld_o  (res_ld),
    .res_o     (res),
    .q_we_o    (q_we),
    .q_waddr_o (q_waddr),
    .q_wdata_o (q_wdata),
    .q_re_o    (q_re),
    .q_raddr_o (q_raddr),
    .q_rdata_i (q_rdata),
    .p_we_o    (p_we),
    .p_waddr_o (p_waddr),
    .p_wdata_o (p_wdata),
    .p_re_o    (p_re),
    .p_raddr_o (p_raddr),
    .p_rdata_i (p_rdata)
  );

  sstq_ram #(
    .Depth(NUM_TIMERS),
    .Width(TIME_BITS + Iw),
    .Aw   (Iw)
  ) u_queue_mem (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .re_i   (q_re),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  sstq_ram #(
    .Depth(NUM_TIMERS),
    .Width(TIME_BITS + 1),
    .Aw   (Iw)
  ) u_period_mem (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sstq_pkg::*;

  localparam int NTimers   = 16;
  localparam int IdleLimit = 40000;
  localparam int NumRandom = 430;

  class timer_queue_predictor;
    logic [31:0] now_ticks;
    logic [31:0] deadline [NTimers];
    logic [31:0] period [NTimers];
    logic        single [NTimers];
    logic        running [NTimers];
    logic [3:0]  order [NTimers];
    int          count;
    out_t        pending_results[$];
    int          errors;

    function new();
      now_ticks = '0;
      count = 0;
      errors = 0;
      for (int i = 0; i < NTimers; i++) begin
        running[i] = 1'b0;
      end
    endfunction

    function void unlink(logic [3:0] id);
      running[id] = 1'b0;
      for (int i = 0; i < count; i++) begin
        if (order[i] == id) begin
          for (int j = i; j + 1 < count; j++) order[j] = order[j + 1];
          count--;
          return;
        end
      end
    endfunction

    function void link(logic [3:0] id, logic [31:0] when);
      int pos;
      pos = 0;
      deadline[id] = when;
      running[id] = 1'b1;
      while (pos < count && deadline[order[pos]] <= when) pos++;
      for (int j = count; j > pos; j--) order[j] = order[j - 1];
      order[pos] = id;
      count++;
    endfunction

    function void note_request(in_t req);
      out_t r;
      int   fired;
      logic [3:0] t;
      fired = 0;
      case (req.req_type)
        ReqStart, ReqStop: begin
          if (running[req.timer_id]) unlink(req.timer_id);
          if (req.req_type == ReqStart) begin
            period[req.timer_id] = req.interval;
            single[req.timer_id] = req.one_shot;
            link(req.timer_id, now_ticks + req.interval);
          end
          r.result_kind = KindAck;
          r.result_timer = req.timer_id;
          r.now_running = running[req.timer_id];
          r.last = 1'b1;
          pending_results.push_back(r);
        end
        ReqTick: begin
          now_ticks = now_ticks + 32'd1;
          while (fired < NTimers && count > 0 && deadline[order[0]] <= now_ticks) begin
            t = order[0];
            unlink(t);
            if (!single[t]) link(t, now_ticks + period[t]);
            r.result_kind = KindFire;
            r.result_timer = t;
            r.now_running = running[t];
            r.last = 1'b0;
            pending_results.push_back(r);
            fired++;
          end
          if (fired > 0) pending_results[$].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, want.result_kind,
                 got.result_kind);
        errors++;
      end
      if (got.result_timer !== want.result_timer) begin
        $display("%0t: result_timer expected %0d actual %0d", $time, want.result_timer,
                 got.result_timer);
        errors++;
      end
      if (got.now_running !== want.now_running) begin
        $display("%0t: now_running expected %0d actual %0d", $time, want.now_running,
                 got.now_running);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  timer_queue_predictor sb = new();
  int  stall_left = 0;
  int  idle_cycles = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  sorted_software_timer_queue_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if (calm || $urandom_range(9) < 5) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  // receiver stall, result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count % 700 == 0) calm = ~calm;
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(9) < 3) begin
          stall_left = ($urandom_range(14) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(item);
  endtask

  task automatic send_req(req_e kind, int id, logic [31:0] ival, logic once);
    in_t item;
    item.req_type = kind;
    item.timer_id = id[3:0];
    item.interval = ival;
    item.one_shot = once;
    send_item(item);
  endtask

  function automatic in_t random_item();
    in_t item;
    int  r;
    r = $urandom_range(99);
    item.req_type = (r < 4) ? ReqNone : (r < 50) ? ReqTick : (r < 80) ? ReqStart : ReqStop;
    item.timer_id = 4'($urandom_range(NTimers - 1));
    r = $urandom_range(99);
    if (r < 70) item.interval = $urandom_range(1, 12);
    else if (r < 88) item.interval = $urandom;
    else item.interval = 32'hFFFF_FFFF - $urandom_range(0, 15);
    if (item.interval == 0) item.interval = 32'd1;
    item.one_shot = 1'($urandom_range(1));
    return item;
  endfunction

  initial begin
    in_t item;
    int  sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(ReqStart, 0, 32'd1, 1'b1);
    send_req(ReqStart, 15, 32'hFFFF_FFFF, 1'b0);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqStop, 15, 32'd0, 1'b0);
    send_req(ReqStop, 15, 32'd0, 1'b0);
    send_req(ReqStart, 3, 32'd2, 1'b0);
    send_req(ReqStart, 3, 32'd2, 1'b0);
    send_req(ReqStart, 4, 32'd2, 1'b1);
    send_req(ReqNone, 7, 32'h5555_AAAA, 1'b1);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqStop, 3, 32'd0, 1'b0);
    send_req(ReqStop, 4, 32'd0, 1'b0);
    // wrapped periodic deadline keeps the timer due, so the tick hits the firing cap
    send_req(ReqStart, 5, 32'hFFFF_FFFF, 1'b0);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqTick, 0, 32'd0, 1'b0);
    send_req(ReqStop, 5, 32'd0, 1'b0);
    send_req(ReqStart, 9, 32'h8000_0000, 1'b1);

    sent = 0;
    while (sent < NumRandom) begin
      item = random_item();
      send_item(item);
      if (item.req_type != ReqNone) sent++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sorted_software_timer_queue_core.f @@
hw/rtl/sstq_pkg.sv
hw/rtl/sstq_ram.sv
hw/rtl/sstq_ctrl.sv
hw/rtl/sorted_software_timer_queue_core.sv
bench/tb.sv
